// File: hdl/bqhp_pkg.sv
// shared types and constants for the biquad high-pass filter
// no dependencies; imported by every module in hdl/
`default_nettype none

package bqhp_pkg;

    localparam int SAMPLE_BITS        = 24;
    localparam int COEF_BITS          = 32;
    localparam int COEF_FRAC_BITS_DEF = 29;
    localparam int CFG_IDX_BITS       = 3;

    // b0 reset value is 1.0 in q3.29
    localparam logic signed [COEF_BITS-1:0] FF_NOW_RESET = 32'sd536870912;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FF_NOW   = 3'd0,
        REG_FF_PREV1 = 3'd1,
        REG_FF_PREV2 = 3'd2,
        REG_FB_PREV1 = 3'd3,
        REG_FB_PREV2 = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          restart;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          clipped;
    } t_out_item;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] ff_gain_now;
        logic signed [COEF_BITS-1:0] ff_gain_prev1;
        logic signed [COEF_BITS-1:0] ff_gain_prev2;
        logic signed [COEF_BITS-1:0] fb_gain_prev1;
        logic signed [COEF_BITS-1:0] fb_gain_prev2;
    } t_coefs;

endpackage

`default_nettype wire

// File: hdl/bqhp_cfg_regs.sv
// coefficient register bank for the biquad high-pass filter
// depends on bqhp_pkg
`default_nettype none

module bqhp_cfg_regs (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_wr_en,
    input  wire  [bqhp_pkg::CFG_IDX_BITS-1:0]      i_wr_index,
    input  wire  [bqhp_pkg::COEF_BITS-1:0]         i_wr_data,
    output bqhp_pkg::t_coefs                       o_coefs
);
    import bqhp_pkg::*;

    t_coefs r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.ff_gain_now   <= FF_NOW_RESET;
            r_coefs.ff_gain_prev1 <= '0;
            r_coefs.ff_gain_prev2 <= '0;
            r_coefs.fb_gain_prev1 <= '0;
            r_coefs.fb_gain_prev2 <= '0;
        end else if (i_wr_en) begin
            // unknown indexes are dropped
            unique case (i_wr_index)
                REG_FF_NOW:   r_coefs.ff_gain_now   <= i_wr_data;
                REG_FF_PREV1: r_coefs.ff_gain_prev1 <= i_wr_data;
                REG_FF_PREV2: r_coefs.ff_gain_prev2 <= i_wr_data;
                REG_FB_PREV1: r_coefs.fb_gain_prev1 <= i_wr_data;
                REG_FB_PREV2: r_coefs.fb_gain_prev2 <= i_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_coefs = r_coefs;

endmodule

`default_nettype wire

// File: hdl/bqhp_datapath.sv
// filter arithmetic and sample history: five products, exact sum,
// round half up, saturate; depends on bqhp_pkg
`default_nettype none

module bqhp_datapath #(
    parameter int COEF_FRAC_BITS = bqhp_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  bqhp_pkg::t_coefs     i_coefs,
    input  bqhp_pkg::t_in_item   i_item,
    input  wire                  i_commit,
    output bqhp_pkg::t_out_item  o_result
);
    import bqhp_pkg::*;

    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + 3;

    localparam logic signed [ACC_W-1:0] HALF_LSB =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] r_x1, r_x2, r_y1, r_y2;
    logic signed [SAMPLE_BITS-1:0] x, x1, x2, y1, y2;
    logic signed [COEF_BITS-1:0]   b0, b1, b2, a1, a2;
    logic signed [PROD_W-1:0]      p0, p1, p2, p3, p4;
    logic signed [ACC_W-1:0]       acc, rounded;
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          clip;

    always_comb begin
        x  = i_item.sample_in;
        // restart zeroes the history before this sample is filtered
        x1 = i_item.restart ? '0 : r_x1;
        x2 = i_item.restart ? '0 : r_x2;
        y1 = i_item.restart ? '0 : r_y1;
        y2 = i_item.restart ? '0 : r_y2;
        b0 = i_coefs.ff_gain_now;
        b1 = i_coefs.ff_gain_prev1;
        b2 = i_coefs.ff_gain_prev2;
        a1 = i_coefs.fb_gain_prev1;
        a2 = i_coefs.fb_gain_prev2;
    end

    assign p0 = b0 * x;
    assign p1 = b1 * x1;
    assign p2 = b2 * x2;
    assign p3 = a1 * y1;
    assign p4 = a2 * y2;

    assign acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2)
               - ACC_W'(p3) - ACC_W'(p4) + HALF_LSB;
    assign rounded = acc >>> COEF_FRAC_BITS;

    always_comb begin
        if (rounded > SAT_HI) begin
            y    = SAT_HI[SAMPLE_BITS-1:0];
            clip = 1'b1;
        end else if (rounded < SAT_LO) begin
            y    = SAT_LO[SAMPLE_BITS-1:0];
            clip = 1'b1;
        end else begin
            y    = rounded[SAMPLE_BITS-1:0];
            clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_commit) begin
            r_x2 <= x1;
            r_x1 <= x;
            r_y2 <= y1;
            r_y1 <= y;
        end
    end

    assign o_result.sample_out = y;
    assign o_result.clipped    = clip;

endmodule

`default_nettype wire

// File: hdl/biquad_highpass_filter_top.sv
// top level of the direct form I biquad high-pass filter
// depends on bqhp_pkg, bqhp_cfg_regs, bqhp_datapath
//
//  channel   direction  handshake                payload
//  --------  ---------  -----------------------  -------------------------------
//  sample    in         i_valid / o_stall        i_in_item (sample_in, restart)
//  result    out        o_valid / i_stall        o_out_item (sample_out, clipped)
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per cycle sustained while i_stall is low; o_valid rises once an
// accepted item has passed the input register, the five multiplies, adder and
// saturation into the result register. the feedback through the output history
// is closed within that single pass. synchronous active-low reset clears
// history, handshake state and coefficients (b0 = 1.0). a stalled result holds
// in the output register while the input register still takes one more item.
`default_nettype none

module biquad_highpass_filter_top #(
    parameter int COEF_FRAC_BITS = bqhp_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  bqhp_pkg::t_in_item                 i_in_item,
    output logic                               o_valid,
    input  wire                                i_stall,
    output bqhp_pkg::t_out_item                o_out_item,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [bqhp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire  [bqhp_pkg::COEF_BITS-1:0]     i_cfg_data
);
    import bqhp_pkg::*;

    t_coefs    coefs;
    t_in_item  r_in_item;
    logic      r_in_valid;
    t_out_item r_out_item;
    logic      r_out_valid;
    t_out_item result;
    logic      advance;
    logic      accept;

    assign o_cfg_ready = 1'b1;

    bqhp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_coefs    (coefs)
    );

    bqhp_datapath #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coefs  (coefs),
        .i_item   (r_in_item),
        .i_commit (advance),
        .o_result (result)
    );

    // the item in the input register moves on when the result slot frees up
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_item = r_out_item;

endmodule

`default_nettype wire
